>>> src/integer_text_parser_top_assert.svh
// Assertion macros shared by the integer text parser modules.
// Expects clk and arst_n in the scope of each use.
`ifndef INTEGER_TEXT_PARSER_TOP_ASSERT_SVH
`define INTEGER_TEXT_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/itp_pkg.sv
// Types and constants for the integer text parser.
// No dependencies; imported by itp_core, integer_text_parser_top and the testbench.
package itp_pkg;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_B     = 8'h62;

	typedef enum logic [1:0] {
		REG_BASE_SELECT = 2'd0,
		REG_MAX_WIDTH   = 2'd1,
		REG_BIN_PREFIX  = 2'd2,
		REG_RESULT_SIZE = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SIZE_8  = 2'd0,
		SIZE_16 = 2'd1,
		SIZE_32 = 2'd2,
		SIZE_64 = 2'd3
	} size_t;

	typedef struct packed {
		logic [4:0]  base_select;
		logic [15:0] max_width;
		logic        binary_prefix_enable;
		size_t       result_size;
	} itp_cfg_t;

	typedef struct packed {
		logic [63:0] value;
		logic        ok;
		logic        pushed_back;
		logic [15:0] chars_used;
	} itp_res_t;

endpackage

>>> src/itp_core.sv
// Field state and per-word step logic of the integer text parser.
// Depends on itp_pkg and the assertion macro header.
`include "integer_text_parser_top_assert.svh"

module itp_core import itp_pkg::*; #(
	parameter int VALUE_BITS = 64,
	parameter int WIDTH_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  logic [7:0] ch,
	input  logic     is_end,
	input  itp_cfg_t cfg,
	output logic     emit,
	output itp_res_t res
);

	typedef enum logic [1:0] {PH_IDLE, PH_SIGN, PH_ZERO, PH_DIGITS} phase_t;

	phase_t                  phase_q, nph;
	logic [VALUE_BITS-1:0]   acc_q, nacc, sval;
	logic [4:0]              rad_q, nrad;
	logic                    neg_q, nneg, any_q, nany;
	logic [WIDTH_BITS-1:0]   wl_q, nwl, cc_q, ncc;
	logic [7:0]              d;
	logic                    done, do_digit, r_ok, r_push;
	logic [63:0]             v64;

	function automatic logic [7:0] digit_val(input logic [7:0] c);
		logic [7:0] r;
		r = 8'hFF;
		if (c >= 8'h30 && c <= 8'h39)
			r = c - 8'h30;
		else if (c >= 8'h61 && c <= 8'h7A)
			r = c - 8'h57;
		else if (c >= 8'h41 && c <= 8'h5A)
			r = c - 8'h37;
		return r;
	endfunction

	always_comb begin
		nph      = phase_q;
		nacc     = acc_q;
		nrad     = rad_q;
		nneg     = neg_q;
		nany     = any_q;
		nwl      = wl_q;
		ncc      = cc_q;
		emit     = 1'b0;
		r_ok     = 1'b0;
		r_push   = 1'b0;
		done     = 1'b0;
		do_digit = 1'b0;
		d        = digit_val(ch);

		if (phase_q == PH_IDLE) begin
			nacc = '0;
			nrad = cfg.base_select;
			nneg = 1'b0;
			nany = 1'b0;
			ncc  = '0;
			nwl  = cfg.max_width[WIDTH_BITS-1:0];
			if (nwl == '0)
				nwl = WIDTH_BITS'(1);
			nph = PH_SIGN;
			if (!is_end && (ch == CH_MINUS || ch == CH_PLUS)) begin
				nneg = (ch == CH_MINUS);
				ncc  = ncc + WIDTH_BITS'(1);
				nwl  = nwl - WIDTH_BITS'(1);
				done = 1'b1;
				if (nwl == '0)
					emit = 1'b1;
			end
		end

		if (!done) begin
			case (nph)
				PH_SIGN: begin
					if (is_end) begin
						emit = 1'b1;
					end else if (ch == CH_ZERO) begin
						nph = PH_ZERO;
						ncc = ncc + WIDTH_BITS'(1);
						nwl = nwl - WIDTH_BITS'(1);
						if (nwl == '0) begin
							emit = 1'b1;
							r_ok = 1'b1;
						end
					end else begin
						if (nrad == 5'd0)
							nrad = 5'd10;
						do_digit = 1'b1;
					end
				end
				PH_ZERO: begin
					if (is_end) begin
						emit = 1'b1;
						r_ok = 1'b1;
					end else begin
						nany = 1'b1;
						if ((ch | 8'h20) == CH_X && (nrad == 5'd0 || nrad == 5'd16)) begin
							nrad = 5'd16;
							nph  = PH_DIGITS;
							ncc  = ncc + WIDTH_BITS'(1);
							nwl  = nwl - WIDTH_BITS'(1);
							if (nwl == '0) begin
								emit = 1'b1;
								r_ok = 1'b1;
							end
						end else if (ch == CH_B && nrad <= 5'd2 && cfg.binary_prefix_enable) begin
							nrad = 5'd2;
							nph  = PH_DIGITS;
							ncc  = ncc + WIDTH_BITS'(1);
							nwl  = nwl - WIDTH_BITS'(1);
							if (nwl == '0) begin
								emit = 1'b1;
								r_ok = 1'b1;
							end
						end else begin
							if (nrad == 5'd0 || nrad == 5'd8)
								nrad = 5'd8;
							do_digit = 1'b1;
						end
					end
				end
				default: begin
					if (is_end) begin
						emit = 1'b1;
						r_ok = nany;
					end else begin
						do_digit = 1'b1;
					end
				end
			endcase
		end

		if (do_digit) begin
			if (d >= {3'b000, nrad}) begin
				emit   = 1'b1;
				r_ok   = nany;
				r_push = 1'b1;
			end else begin
				nacc = nacc * VALUE_BITS'(nrad) + VALUE_BITS'(d);
				nany = 1'b1;
				nph  = PH_DIGITS;
				ncc  = ncc + WIDTH_BITS'(1);
				nwl  = nwl - WIDTH_BITS'(1);
				if (nwl == '0) begin
					emit = 1'b1;
					r_ok = 1'b1;
				end
			end
		end

		if (emit)
			nph = PH_IDLE;
	end

	always_comb begin
		sval = nneg ? (VALUE_BITS'(0) - nacc) : nacc;
		v64  = 64'(sval);
		case (cfg.result_size)
			SIZE_8:  v64 = {56'd0, v64[7:0]};
			SIZE_16: v64 = {48'd0, v64[15:0]};
			SIZE_32: v64 = {32'd0, v64[31:0]};
			default: v64 = v64;
		endcase
		res.value       = r_ok ? v64 : 64'd0;
		res.ok          = r_ok;
		res.pushed_back = r_push;
		res.chars_used  = 16'(ncc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			rad_q   <= '0;
			neg_q   <= 1'b0;
			any_q   <= 1'b0;
			wl_q    <= '0;
			cc_q    <= '0;
		end else if (fire) begin
			phase_q <= nph;
			acc_q   <= nacc;
			rad_q   <= nrad;
			neg_q   <= nneg;
			any_q   <= nany;
			wl_q    <= nwl;
			cc_q    <= ncc;
		end
	end

	`ITP_ASSERT_NOW(a_width_live, phase_q != PH_IDLE, wl_q != '0, "width limit exhausted mid-field")
	`ITP_ASSERT_NEXT(a_end_idle, fire && emit, phase_q == PH_IDLE, "field did not close after result")
	`ITP_ASSERT_NEXT(a_acc_hold, !fire, $stable(acc_q) && $stable(cc_q), "field state moved without a word")

endmodule

>>> src/integer_text_parser_top.sv
// Integer text parser top level: input register, config registers, result register.
// Depends on itp_pkg, itp_core and the assertion macro header.
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid/in_ready  | ch, is_end
//   out     | from block| out_valid/out_ready| value, ok, pushed_back, chars_used
//   cfg     | to block  | APB psel/penable   | paddr, pwdata, prdata
//
// One word per cycle while no field-ending word stalls; each result is held in the result register.
// The field state update (one multiply-add by the radix) sits between the input and result registers.
// A full result register stalls only words that end a field; other words keep flowing.
// Asynchronous reset returns the field state to idle and the config and valid flags to defaults.
`include "integer_text_parser_top_assert.svh"

module integer_text_parser_top import itp_pkg::*; #(
	parameter int VALUE_BITS = 64,
	parameter int WIDTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        is_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic        ok,
	output logic        pushed_back,
	output logic [15:0] chars_used,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	itp_cfg_t    cfg_q;
	logic        valid_s1, is_end_s1;
	logic [7:0]  ch_s1;
	logic        advance, emit;
	itp_res_t    res, res_q;
	logic        out_valid_q;
	logic        wr;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_select          <= 5'd0;
			cfg_q.max_width            <= 16'hFFFF;
			cfg_q.binary_prefix_enable <= 1'b0;
			cfg_q.result_size          <= SIZE_32;
		end else if (wr) begin
			unique case (idx)
				REG_BASE_SELECT: cfg_q.base_select          <= pwdata[4:0];
				REG_MAX_WIDTH:   cfg_q.max_width            <= pwdata[15:0];
				REG_BIN_PREFIX:  cfg_q.binary_prefix_enable <= pwdata[0];
				REG_RESULT_SIZE: cfg_q.result_size          <= size_t'(pwdata[1:0]);
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BASE_SELECT: prdata = {27'd0, cfg_q.base_select};
			REG_MAX_WIDTH:   prdata = {16'd0, cfg_q.max_width};
			REG_BIN_PREFIX:  prdata = {31'd0, cfg_q.binary_prefix_enable};
			REG_RESULT_SIZE: prdata = {30'd0, cfg_q.result_size};
		endcase
	end

	assign advance  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1     <= ch;
			is_end_s1 <= is_end;
		end
	end

	itp_core #(
		.VALUE_BITS(VALUE_BITS),
		.WIDTH_BITS(WIDTH_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.ch    (ch_s1),
		.is_end(is_end_s1),
		.cfg   (cfg_q),
		.emit  (emit),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign value       = res_q.value;
	assign ok          = res_q.ok;
	assign pushed_back = res_q.pushed_back;
	assign chars_used  = res_q.chars_used;

	`ITP_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(ch_s1) && $stable(is_end_s1), "input word lost while stalled")
	`ITP_ASSERT_NOW(a_fail_zero, out_valid_q && !res_q.ok, res_q.value == 64'd0, "failed field carries a value")
	`ITP_ASSERT_NEXT(a_result_lands, advance && emit, out_valid_q, "result word not presented")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for integer_text_parser_top: queued character words, APB set-up,
// a word-level parser predictor and a result check. Depends on itp_pkg and the RTL.
module tb;
	import itp_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_SIGN, PH_ZERO, PH_DIGITS} fld_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} char_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  ch = 8'h00;
	logic        is_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] value;
	logic        ok;
	logic        pushed_back;
	logic [15:0] chars_used;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	integer_text_parser_top i_dut (.*);

	always #2 clk = ~clk;

	// configuration shadow
	logic [4:0]  cfg_base = 5'd0;
	logic [15:0] cfg_width = 16'hFFFF;
	logic        cfg_binpfx = 1'b0;
	size_t       cfg_size = SIZE_32;

	// field state
	fld_phase_t  fld_phase = PH_IDLE;
	logic [63:0] fld_acc = '0;
	logic [4:0]  fld_radix = '0;
	logic        fld_neg = 1'b0;
	logic        fld_any = 1'b0;
	logic [15:0] fld_left = '0;
	logic [15:0] fld_count = '0;

	itp_res_t    expected_fields[$];
	char_word_t  char_queue[$];
	char_word_t  next_word;
	itp_res_t    want;
	int          words_queued = 0;
	int          words_done = 0;
	int          mismatches = 0;
	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;
	logic        in_idle = 1'b1;
	logic        out_idle = 1'b1;
	int          in_wait = 0;
	int          out_wait = 0;
	int          draw;

	function automatic logic [7:0] digit_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "z") return c - "a" + 8'd10;
		if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
		return 8'hFF;
	endfunction

	function automatic void close_field(logic good, logic pb);
		itp_res_t r;
		logic [63:0] v;
		v = '0;
		if (good) begin
			v = fld_neg ? -fld_acc : fld_acc;
			case (cfg_size)
				SIZE_8: v &= 64'hFF;
				SIZE_16: v &= 64'hFFFF;
				SIZE_32: v &= 64'hFFFF_FFFF;
				default: ;
			endcase
		end
		r.value = v;
		r.ok = good;
		r.pushed_back = pb;
		r.chars_used = fld_count;
		expected_fields.push_back(r);
		fld_phase = PH_IDLE;
	endfunction

	function automatic logic consume_char();
		fld_count = fld_count + 16'd1;
		fld_left = fld_left - 16'd1;
		return fld_left == 16'd0;
	endfunction

	function automatic void digit_step(logic [7:0] c);
		logic [7:0] d;
		d = digit_of(c);
		if (d >= fld_radix) begin
			close_field(fld_any, 1'b1);
			return;
		end
		fld_acc = fld_acc * fld_radix + d;
		fld_any = 1'b1;
		fld_phase = PH_DIGITS;
		if (consume_char()) close_field(1'b1, 1'b0);
	endfunction

	function automatic void parse_step(logic [7:0] c, logic e);
		logic took_prefix;
		took_prefix = 1'b0;
		if (fld_phase == PH_IDLE) begin
			fld_acc = '0;
			fld_radix = cfg_base;
			fld_neg = 1'b0;
			fld_any = 1'b0;
			fld_count = '0;
			fld_left = (cfg_width == 16'd0) ? 16'd1 : cfg_width;
			fld_phase = PH_SIGN;
			if (!e && (c == CH_MINUS || c == CH_PLUS)) begin
				fld_neg = (c == CH_MINUS);
				if (consume_char()) close_field(1'b0, 1'b0);
				return;
			end
		end
		case (fld_phase)
			PH_SIGN: begin
				if (e) begin
					close_field(1'b0, 1'b0);
				end else if (c == CH_ZERO) begin
					fld_phase = PH_ZERO;
					if (consume_char()) close_field(1'b1, 1'b0);
				end else begin
					if (fld_radix == 5'd0) fld_radix = 5'd10;
					digit_step(c);
				end
			end
			PH_ZERO: begin
				if (e) begin
					close_field(1'b1, 1'b0);
				end else begin
					fld_any = 1'b1;
					if ((c | 8'h20) == CH_X && (fld_radix == 5'd0 || fld_radix == 5'd16)) begin
						fld_radix = 5'd16;
						took_prefix = 1'b1;
					end else if (c == CH_B && fld_radix <= 5'd2 && cfg_binpfx) begin
						fld_radix = 5'd2;
						took_prefix = 1'b1;
					end else begin
						if (fld_radix == 5'd0 || fld_radix == 5'd8) fld_radix = 5'd8;
						digit_step(c);
					end
					if (took_prefix) begin
						fld_phase = PH_DIGITS;
						if (consume_char()) close_field(1'b1, 1'b0);
					end
				end
			end
			default: begin
				if (e) close_field(fld_any, 1'b0);
				else digit_step(c);
			end
		endcase
	endfunction

	function automatic void compare_field(string what, logic [63:0] exp_v, logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s expected %h, got %h", $time, what, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			out_taken <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				if (expected_fields.size() == 0) begin
					$display("%0t ns: unexpected result value %h ok %b pushed_back %b chars_used %0d",
						$time, value, ok, pushed_back, chars_used);
					mismatches++;
				end else begin
					want = expected_fields.pop_front();
					compare_field("value", want.value, value);
					compare_field("ok", 64'(want.ok), 64'(ok));
					compare_field("pushed_back", 64'(want.pushed_back), 64'(pushed_back));
					compare_field("chars_used", 64'(want.chars_used), 64'(chars_used));
				end
			end
			if (in_valid && in_ready) begin
				parse_step(ch, is_end);
				words_done++;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_wait != 0) begin
				in_valid <= 1'b0;
				in_wait <= in_wait - 1;
			end else if (char_queue.size() != 0) begin
				next_word = char_queue.pop_front();
				in_valid <= 1'b1;
				ch <= next_word.ch;
				is_end <= next_word.is_end;
				if ($urandom_range(0, 31) == 0) in_idle <= ~in_idle;
				in_wait <= in_idle ? $urandom_range(0, 8) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_taken) begin
			if ($urandom_range(0, 31) == 0) out_idle <= ~out_idle;
			draw = out_idle ? $urandom_range(0, 8) : 0;
			out_ready <= (draw == 0);
			out_wait <= (draw == 0) ? 0 : draw - 1;
		end else if (out_wait != 0) begin
			out_ready <= 1'b0;
			out_wait <= out_wait - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_BASE_SELECT: cfg_base = data[4:0];
			REG_MAX_WIDTH: cfg_width = data[15:0];
			REG_BIN_PREFIX: cfg_binpfx = data[0];
			default: cfg_size = size_t'(data[1:0]);
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void push_char(logic [7:0] c);
		char_queue.push_back('{c, 1'b0});
		words_queued++;
	endfunction

	function automatic void push_end();
		char_queue.push_back('{8'($urandom_range(0, 255)), 1'b1});
		words_queued++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endfunction

	function automatic logic [7:0] digit_char(int v);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
	endfunction

	task automatic queue_field();
		int n;
		int radix;
		if ($urandom_range(0, 9) < 2) begin
			n = $urandom_range(1, 6);
			repeat (n)
				if ($urandom_range(0, 7) == 0) push_end();
				else push_char(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 5))
			0: push_char(CH_MINUS);
			1: push_char(CH_PLUS);
			default: ;
		endcase
		radix = cfg_base;
		if (radix == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					radix = 16;
					push_char(CH_ZERO);
					push_char($urandom_range(0, 1) ? CH_X : "X");
				end
				1: begin
					radix = 2;
					push_char(CH_ZERO);
					push_char(CH_B);
				end
				2: begin
					radix = 8;
					push_char(CH_ZERO);
				end
				default: begin
					radix = 10;
					push_char("1" + 8'($urandom_range(0, 8)));
				end
			endcase
		end else if ($urandom_range(0, 3) == 0 && (radix == 16 || radix <= 2)) begin
			push_char(CH_ZERO);
			push_char(radix == 16 ? CH_X : CH_B);
		end
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 25) : $urandom_range(0, 6);
		repeat (n) push_char(digit_char($urandom_range(0, radix - 1)));
		case ($urandom_range(0, 2))
			0: push_end();
			1: push_char(8'($urandom_range(0, 255)));
			default: push_char(" ");
		endcase
	endtask

	task automatic drain();
		while (!(words_done == words_queued && expected_fields.size() == 0)) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(logic [4:0] base, logic [15:0] width, logic bp, size_t sz, int n);
		int target;
		write_reg(REG_BASE_SELECT, 32'(base));
		write_reg(REG_MAX_WIDTH, 32'(width));
		write_reg(REG_BIN_PREFIX, 32'(bp));
		write_reg(REG_RESULT_SIZE, 32'(sz));
		target = words_queued + n;
		while (words_queued < target) queue_field();
		push_end();
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: automatic base, full width, 32-bit result
		push_text("-0x1F");
		push_end();
		push_char(CH_PLUS);
		push_end();
		push_end();
		push_text("0 ");
		push_text("0x");
		push_end();
		push_text("-z");
		push_char(8'hFF);
		push_text("987");
		push_end();
		push_text("08");
		push_char(8'h00);
		drain();

		run_phase(5'd0, 16'hFFFF, 1'b1, SIZE_64, 80);
		run_phase(5'd16, 16'hFFFF, 1'b0, SIZE_8, 80);
		run_phase(5'd10, 16'd1, 1'b0, SIZE_16, 80);
		run_phase(5'd8, 16'd0, 1'b1, SIZE_32, 80);
		run_phase(5'd2, 16'd6, 1'b1, SIZE_64, 80);
		run_phase(5'd0, 16'd4, 1'b1, SIZE_8, 80);
		run_phase(5'd1, 16'hFFFF, 1'b0, SIZE_16, 80);
		run_phase(5'd13, 16'd9, 1'b1, SIZE_32, 80);
		run_phase(5'd31, 16'hFFFF, 1'b0, SIZE_64, 80);
		run_phase(5'd0, 16'd12, 1'b0, SIZE_64, 80);
		run_phase(5'd0, 16'hFFFF, 1'b0, SIZE_32, 80);

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
